>>> rtl/b2sp_pkg.sv
// ----------------------------------------------------------------------------
// b2sp_pkg
// Shared constants, types and helper functions of the BLAKE2sp hash engine.
// ----------------------------------------------------------------------------
package b2sp_pkg;

  localparam int LEAF_COUNT  = 8;
  localparam int ROUND_COUNT = 10;

  localparam int CNT_W    = 6;
  localparam int NODE_W   = 4;
  localparam int MSG_DEPTH = LEAF_COUNT * 16;
  localparam int MSG_AW    = 7;
  localparam int CV_DEPTH  = (LEAF_COUNT + 1) * 8;
  localparam int CV_AW     = 7;

  localparam logic [CNT_W-1:0]  LOAD_LAST  = 6'd24;
  localparam logic [CNT_W-1:0]  ROUND_LAST = 6'(ROUND_COUNT * 4 - 1);
  localparam logic [CNT_W-1:0]  WRB_LAST   = 6'd7;
  localparam logic [NODE_W-1:0] LEAF_LAST  = 4'd7;
  localparam logic [NODE_W-1:0] NODE_ROOT  = 4'd8;
  localparam logic [1:0]        BLK_LAST   = 2'd3;
  localparam logic [6:0]        FULL_FILL  = 7'd64;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_LOAD, ST_INIT, ST_ROUND, ST_XOR, ST_WRB, ST_STORE, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    JOB_LEAF, JOB_LEAF_FIN, JOB_ROOT
  } job_e;

  typedef struct packed {
    logic              accept;
    logic              load;
    logic              init;
    logic              round;
    logic              fold;
    logic              wrb;
    logic              store;
    logic              clear;
    logic [CNT_W-1:0]  cnt;
    job_e              job;
    logic [NODE_W-1:0] node;
    logic [1:0]        blk;
  } cmd_t;

  typedef struct packed {
    logic       need_compress;
    logic       last;
    logic [2:0] leaf;
  } status_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // Reset chain value word of a tree node: leaves carry their offset, the root depth 1.
  function automatic logic [31:0] node_init_word(logic [NODE_W-1:0] node, logic [2:0] idx);
    logic [31:0] w;
    w = IV[idx];
    if (idx == 3'd0) w = w ^ 32'h02080020;
    if (idx == 3'd2 && node != NODE_ROOT) w = w ^ {29'd0, node[2:0]};
    if (idx == 3'd3) w = w ^ ((node == NODE_ROOT) ? 32'h20010000 : 32'h20000000);
    return w;
  endfunction

  // One half of the G function; the second half uses rotations of 8 and 7.
  function automatic quad_t half_g(quad_t q, logic [31:0] x, logic second);
    quad_t r;
    logic [31:0] t;
    r.a = q.a + q.b + x;
    t = q.d ^ r.a;
    r.d = second ? {t[7:0], t[31:8]} : {t[15:0], t[31:16]};
    r.c = q.c + r.d;
    t = q.b ^ r.c;
    r.b = second ? {t[6:0], t[31:7]} : {t[11:0], t[31:12]};
    return r;
  endfunction

endpackage

>>> rtl/blake2sp_hash_engine.sv
// ----------------------------------------------------------------------------
// blake2sp_hash_engine
// Unkeyed BLAKE2sp hasher with a 32-byte digest over a stream of 32-bit words.
// ----------------------------------------------------------------------------
// Usage: message words enter on the input channel (in_valid_i / in_ready_o),
// first byte in bits 7:0. Every word but the last carries four bytes; the word
// with end_of_message_i set carries valid_bytes_i bytes (0 to 4).
// A word that needs no compression passes the idle, check and store states.
// A word that starts a new block for a leaf whose block is full first
// compresses that block: it loads block and chain value, sets up the work
// vector, runs ten rounds of four G lanes at a half step each, then folds
// and writes back. These compressions on the shared G lanes set the
// throughput. The last word triggers eight leaf and four root compressions,
// after which the eight digest words leave on the output channel
// (out_valid_o / out_ready_i), word 0 first, last_word_o on the eighth.
// The output holds its word while the receiver stalls; no new input word is
// taken until the digest has been fully delivered. After that the engine is
// back in its reset state and ready for the next message. Reset clears the
// chain value valid bits, counters and stream position at once; no sweep.
// ----------------------------------------------------------------------------
module blake2sp_hash_engine
  import b2sp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] word_data_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  cmd_t    cmd;
  status_t status;

  // The sequencer owns all timing; the datapath only follows its commands.
  b2sp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o)
  );

  b2sp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .word_data_i     (word_data_i),
    .valid_bytes_i   (valid_bytes_i),
    .end_of_message_i(end_of_message_i),
    .status_o        (status),
    .digest_word_o   (digest_word_o)
  );

  // During emission the step counter walks the digest words.
  assign word_index_o = cmd.cnt[2:0];
  assign last_word_o  = (cmd.cnt[2:0] == 3'd7);

endmodule

>>> rtl/b2sp_ram.sv
// ----------------------------------------------------------------------------
// b2sp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module b2sp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/b2sp_datapath.sv
// ----------------------------------------------------------------------------
// b2sp_datapath
// Message and chain value stores, byte counters, work vector and G lanes.
// ----------------------------------------------------------------------------
module b2sp_datapath
  import b2sp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [31:0] word_data_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        end_of_message_i,
  output status_t     status_o,
  output logic [31:0] digest_word_o
);

  localparam logic [3:0] COL_IDX [4][4] = '{
    '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
    '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15}
  };
  localparam logic [3:0] DIAG_IDX [4][4] = '{
    '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
    '{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}
  };

  // Control state.
  logic [8:0]  pos_q, pos_d;
  logic [6:0]  fill_q [LEAF_COUNT];
  logic [63:0] count_q [LEAF_COUNT + 1];
  logic [LEAF_COUNT:0] valid_q;

  // Payload registers.
  logic [31:0] item_word_q;
  logic [2:0]  item_nbytes_q;
  logic        item_last_q;
  logic [31:0] m_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [16];

  logic [2:0]  nbytes;
  logic [31:0] masked_word;
  logic [2:0]  leaf;
  logic [3:0]  wpos;
  logic [6:0]  node_fill;
  logic [4:0]  keep_words;
  logic [4:0]  cap_idx;
  logic [31:0] msg_rdata, cv_rdata;
  logic        msg_we, cv_we;
  logic [MSG_AW-1:0] msg_waddr, msg_raddr;
  logic [CV_AW-1:0]  cv_waddr, cv_raddr;
  logic [63:0] t_sum;
  logic        fin0, fin1;
  logic        diag, second;
  logic [3:0]  rnd;
  logic [3:0]  lane_idx [4][4];
  quad_t       lane_out [4];
  logic [31:0] v_rnd [16];
  logic [31:0] cap_src;

  always_comb begin
    nbytes = 3'd4;
    if (end_of_message_i && valid_bytes_i < 3'd4) nbytes = valid_bytes_i;
    unique case (nbytes)
      3'd0:    masked_word = 32'd0;
      3'd1:    masked_word = {24'd0, word_data_i[7:0]};
      3'd2:    masked_word = {16'd0, word_data_i[15:0]};
      3'd3:    masked_word = {8'd0, word_data_i[23:0]};
      default: masked_word = word_data_i;
    endcase
  end

  assign leaf = pos_q[8:6];
  assign wpos = pos_q[5:2];
  assign pos_d = pos_q + {6'd0, item_nbytes_q};

  assign status_o.leaf = leaf;
  assign status_o.last = item_last_q;
  assign status_o.need_compress = (item_nbytes_q != 3'd0) && (wpos == 4'd0) &&
                                  (fill_q[leaf] == FULL_FILL);

  assign node_fill  = fill_q[cmd_i.node[2:0]];
  assign keep_words = 5'((node_fill + 7'd3) >> 2);
  assign cap_idx    = cmd_i.cnt[4:0] - 5'd1;

  // Store addressing.
  assign msg_we    = cmd_i.store && (item_nbytes_q != 3'd0);
  assign msg_waddr = {leaf, wpos};
  assign msg_raddr = {cmd_i.node[2:0], cmd_i.cnt[3:0]};
  assign cv_we     = cmd_i.wrb;
  assign cv_waddr  = {cmd_i.node, cmd_i.cnt[2:0]};
  assign cv_raddr  = (cmd_i.cnt < 6'd16) ? {1'b0, cmd_i.blk, cmd_i.cnt[3:0]}
                                         : {cmd_i.node, cmd_i.cnt[2:0]};

  b2sp_ram #(.WIDTH(32), .DEPTH(MSG_DEPTH)) u_msg_ram (
    .clk_i  (clk_i),
    .we_i   (msg_we),
    .waddr_i(msg_waddr),
    .wdata_i(item_word_q),
    .raddr_i(msg_raddr),
    .rdata_o(msg_rdata)
  );

  b2sp_ram #(.WIDTH(32), .DEPTH(CV_DEPTH)) u_cv_ram (
    .clk_i  (clk_i),
    .we_i   (cv_we),
    .waddr_i(cv_waddr),
    .wdata_i(h_q[cmd_i.cnt[2:0]]),
    .raddr_i(cv_raddr),
    .rdata_o(cv_rdata)
  );

  assign t_sum = count_q[cmd_i.node] +
                 ((cmd_i.job == JOB_LEAF_FIN) ? {57'd0, node_fill} : 64'd64);
  assign fin0 = (cmd_i.job == JOB_LEAF_FIN) ||
                (cmd_i.job == JOB_ROOT && cmd_i.blk == BLK_LAST);
  assign fin1 = (cmd_i.job == JOB_LEAF_FIN && cmd_i.node == LEAF_LAST) ||
                (cmd_i.job == JOB_ROOT && cmd_i.blk == BLK_LAST);

  // Four G lanes work on one half step of a column or diagonal round.
  assign rnd    = cmd_i.cnt[5:2];
  assign diag   = cmd_i.cnt[1];
  assign second = cmd_i.cnt[0];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    for (genvar k = 0; k < 4; k++) begin : g_pos
      assign lane_idx[g][k] = diag ? DIAG_IDX[g][k] : COL_IDX[g][k];
    end
    assign lane_out[g] = half_g('{a: v_q[lane_idx[g][0]], b: v_q[lane_idx[g][1]],
                                  c: v_q[lane_idx[g][2]], d: v_q[lane_idx[g][3]]},
                                m_q[SIGMA[rnd][{diag, 2'(g), second}]], second);
  end

  always_comb begin
    v_rnd = v_q;
    for (int g = 0; g < 4; g++) begin
      v_rnd[lane_idx[g][0]] = lane_out[g].a;
      v_rnd[lane_idx[g][1]] = lane_out[g].b;
      v_rnd[lane_idx[g][2]] = lane_out[g].c;
      v_rnd[lane_idx[g][3]] = lane_out[g].d;
    end
  end

  assign cap_src = (cmd_i.job == JOB_ROOT) ? cv_rdata : msg_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= '0;
      for (int i = 0; i < LEAF_COUNT; i++) fill_q[i] <= '0;
      for (int i = 0; i <= LEAF_COUNT; i++) count_q[i] <= '0;
    end else if (cmd_i.clear) begin
      pos_q   <= '0;
      valid_q <= '0;
      for (int i = 0; i < LEAF_COUNT; i++) fill_q[i] <= '0;
      for (int i = 0; i <= LEAF_COUNT; i++) count_q[i] <= '0;
    end else begin
      if (msg_we) begin
        pos_q        <= pos_d;
        fill_q[leaf] <= {1'b0, wpos, 2'b00} + {4'd0, item_nbytes_q};
      end
      if (cmd_i.init) count_q[cmd_i.node] <= t_sum;
      if (cmd_i.fold) valid_q[cmd_i.node] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_word_q   <= masked_word;
      item_nbytes_q <= nbytes;
      item_last_q   <= end_of_message_i;
    end
    if (cmd_i.load && cmd_i.cnt != 6'd0) begin
      if (!cap_idx[4]) begin
        m_q[cap_idx[3:0]] <= (cmd_i.job == JOB_ROOT || cap_idx < keep_words) ? cap_src : 32'd0;
      end else begin
        h_q[cap_idx[2:0]] <= valid_q[cmd_i.node] ? cv_rdata
                                                 : node_init_word(cmd_i.node, cap_idx[2:0]);
      end
    end
    if (cmd_i.init) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
      for (int i = 8; i < 12; i++) begin
        v_q[i] <= IV[i-8];
      end
      v_q[12] <= IV[4] ^ t_sum[31:0];
      v_q[13] <= IV[5] ^ t_sum[63:32];
      v_q[14] <= IV[6] ^ {32{fin0}};
      v_q[15] <= IV[7] ^ {32{fin1}};
    end else if (cmd_i.round) begin
      v_q <= v_rnd;
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
      end
    end
  end

  assign digest_word_o = h_q[cmd_i.cnt[2:0]];

endmodule

>>> rtl/b2sp_ctrl.sv
// ----------------------------------------------------------------------------
// b2sp_ctrl
// Sequencer: word intake, leaf and root compressions, digest emission.
// ----------------------------------------------------------------------------
module b2sp_ctrl
  import b2sp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_ready_o,
  output logic    out_valid_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  job_e              job_q, job_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [1:0]        blk_q, blk_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    job_d   = job_q;
    node_d  = node_q;
    blk_d   = blk_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_d = '0;
        if (status_i.need_compress) begin
          state_d = ST_LOAD;
          job_d   = JOB_LEAF;
          node_d  = {1'b0, status_i.leaf};
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cnt_d = '0;
        if (status_i.last) begin
          state_d = ST_LOAD;
          job_d   = JOB_LEAF_FIN;
          node_d  = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == LOAD_LAST) state_d = ST_INIT;
      end
      ST_INIT: begin
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == ROUND_LAST) state_d = ST_XOR;
      end
      ST_XOR: begin
        cnt_d   = '0;
        state_d = ST_WRB;
      end
      ST_WRB: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == WRB_LAST) begin
          cnt_d = '0;
          priority if (job_q == JOB_LEAF) begin
            state_d = ST_STORE;
          end else if (job_q == JOB_LEAF_FIN && node_q != LEAF_LAST) begin
            state_d = ST_LOAD;
            node_d  = node_q + 4'd1;
          end else if (job_q == JOB_LEAF_FIN) begin
            state_d = ST_LOAD;
            job_d   = JOB_ROOT;
            node_d  = NODE_ROOT;
            blk_d   = '0;
          end else if (blk_q != BLK_LAST) begin
            state_d = ST_LOAD;
            blk_d   = blk_q + 2'd1;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q[2:0] == 3'd7) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    out_valid_o  = (state_q == ST_EMIT);
    cmd_o.accept = in_ready_o && in_valid_i;
    cmd_o.load   = (state_q == ST_LOAD);
    cmd_o.init   = (state_q == ST_INIT);
    cmd_o.round  = (state_q == ST_ROUND);
    cmd_o.fold   = (state_q == ST_XOR);
    cmd_o.wrb    = (state_q == ST_WRB);
    cmd_o.store  = (state_q == ST_STORE);
    cmd_o.clear  = out_valid_o && out_ready_i && (cnt_q[2:0] == 3'd7);
    cmd_o.cnt    = cnt_q;
    cmd_o.job    = job_q;
    cmd_o.node   = node_q;
    cmd_o.blk    = blk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      job_q   <= JOB_LEAF;
      node_q  <= '0;
      blk_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      job_q   <= job_d;
      node_q  <= node_d;
      blk_q   <= blk_d;
    end
  end

`ifndef ASSERT_OFF
  a_round_to_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && cnt_q == ROUND_LAST) |=> (state_q == ST_XOR))
    else $error("round sequence did not end in the feed-forward step");
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_ready_i && cnt_q[2:0] == 3'd7) |=> (state_q == ST_IDLE))
    else $error("engine did not return to idle after the last digest word");
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (cnt_q <= LOAD_LAST))
    else $error("load counter ran past the block");
`endif

endmodule
